// ----- sv/spring_pair_force_accumulator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// spring pair force accumulator assertion macros
// immediate-implication and next-cycle-implication checks, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef SPRING_PAIR_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH
`define SPRING_PAIR_FORCE_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define SPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spring pair accumulator check failed");
`define SPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spring pair accumulator check failed");
`else
`define SPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// shared widths, queue entry type, sequencer states and register indexes
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_SPRINGS   = 64;

    localparam int POS_W   = 32;
    localparam int RAD_W   = 31;
    localparam int K_W     = 32;
    localparam int DELTA_W = POS_W + 1;
    localparam int REST_W  = RAD_W + 1;
    localparam int SQR_W   = 2 * DELTA_W;
    localparam int SQ_W    = SQR_W + 2;
    localparam int D_W     = SQ_W / 2;
    localparam int RT_W    = D_W + 3;
    localparam int UE_W    = D_W + 1;
    localparam int KUD_W   = 64;
    localparam int NUM_W   = KUD_W + UE_W;
    localparam int DEN_W   = D_W + FRACTION_BITS;
    localparam int QUO_W   = K_W + UE_W - FRACTION_BITS;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 7;
    localparam int QDEPTH  = 2;

    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_ELASTIC = 1'b1;

    typedef struct packed {
        logic                      active;
        logic                      last;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [DELTA_W-1:0] dz;
        logic        [REST_W-1:0]  rest;
    } pair_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUMSQ,
        ST_SQRT,
        ST_EXT,
        ST_KMUL,
        ST_PMUL,
        ST_PSUM,
        ST_DIVGO,
        ST_DIV,
        ST_ACC
    } seq_state_t;

endpackage

// ----- sv/spring_pair_force_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// spring_pair_force_accumulator_unit
// hookean spring force sum over an agent's springs, signed fixed point
//
//   channel   direction  handshake           payload
//   item      in         item_valid/stall    positions, radii, flags
//   result    out        result_valid/stall  force_x/y/z, springs_applied, saturated
//   cfg       in         cfg_valid/ready     cfg_index, cfg_data
//
// a contributing spring passes through the 34-step square root
// and the 51-step dividers, run for x, y and z side by side
// a skipped spring goes from idle straight to the accumulate step
// a two-entry queue keeps taking requests while the sequencer is busy, until it is full
// a last spring waits in its final step while an earlier result is stalled
// reset clears sums, count, queue and both config registers
// ----------------------------------------------------------------------------
module spring_pair_force_accumulator_unit
#(
    parameter int MAX_SPRINGS = spa_pkg::MAX_SPRINGS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [spa_pkg::POS_W-1:0]  self_x,
    input  logic signed [spa_pkg::POS_W-1:0]  self_y,
    input  logic signed [spa_pkg::POS_W-1:0]  self_z,
    input  logic signed [spa_pkg::POS_W-1:0]  other_x,
    input  logic signed [spa_pkg::POS_W-1:0]  other_y,
    input  logic signed [spa_pkg::POS_W-1:0]  other_z,
    input  logic        [spa_pkg::RAD_W-1:0]  self_radius,
    input  logic        [spa_pkg::RAD_W-1:0]  other_radius,
    input  logic                              pair_valid,
    input  logic                              self_movable,
    input  logic                              last_pair,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [spa_pkg::SUM_W-1:0]  force_x,
    output logic signed [spa_pkg::SUM_W-1:0]  force_y,
    output logic signed [spa_pkg::SUM_W-1:0]  force_z,
    output logic [spa_pkg::CNT_W-1:0]         springs_applied,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [spa_pkg::K_W-1:0]           cfg_data
);

    logic                    enable_reg;
    logic [spa_pkg::K_W-1:0] k_reg;
    logic                    q_valid;
    logic                    q_pop;
    spa_pkg::pair_t          q_head;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            k_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spa_pkg::CFG_ENABLE:  enable_reg <= cfg_data[0];
                spa_pkg::CFG_ELASTIC: k_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    spa_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .self_x       (self_x),
        .self_y       (self_y),
        .self_z       (self_z),
        .other_x      (other_x),
        .other_y      (other_y),
        .other_z      (other_z),
        .self_radius  (self_radius),
        .other_radius (other_radius),
        .pair_valid   (pair_valid),
        .self_movable (self_movable),
        .last_pair    (last_pair),
        .enable       (enable_reg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop)
    );

    spa_back #(.MAX_SPRINGS(MAX_SPRINGS)) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_head           (q_head),
        .q_pop            (q_pop),
        .stiffness        (k_reg),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .force_x          (force_x),
        .force_y          (force_y),
        .force_z          (force_z),
        .springs_applied  (springs_applied),
        .saturated        (saturated)
    );

endmodule

// ----- sv/spa_front.sv -----
// ----------------------------------------------------------------------------
// spa_front
// accepts spring requests, forms separations and rest length, queues them
// ----------------------------------------------------------------------------
module spa_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic signed [spa_pkg::POS_W-1:0]  self_x,
    input  logic signed [spa_pkg::POS_W-1:0]  self_y,
    input  logic signed [spa_pkg::POS_W-1:0]  self_z,
    input  logic signed [spa_pkg::POS_W-1:0]  other_x,
    input  logic signed [spa_pkg::POS_W-1:0]  other_y,
    input  logic signed [spa_pkg::POS_W-1:0]  other_z,
    input  logic        [spa_pkg::RAD_W-1:0]  self_radius,
    input  logic        [spa_pkg::RAD_W-1:0]  other_radius,
    input  logic                              pair_valid,
    input  logic                              self_movable,
    input  logic                              last_pair,
    input  logic                              enable,
    output logic                              q_valid,
    output spa_pkg::pair_t                    q_head,
    input  logic                              q_pop
);

    localparam int PTR_W = $clog2(spa_pkg::QDEPTH);
    localparam int QC_W  = $clog2(spa_pkg::QDEPTH + 1);

    spa_pkg::pair_t   entry_reg [spa_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0]  fill_reg;
    spa_pkg::pair_t   entry_in;
    logic             push;
    logic             pop;

    assign item_stall = (fill_reg == QC_W'(spa_pkg::QDEPTH));
    assign q_valid    = (fill_reg != '0);
    assign q_head     = entry_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = q_pop && q_valid;

    // classify and form the separation
    always_comb
    begin
        entry_in.active = enable && pair_valid && self_movable;
        entry_in.last   = last_pair;
        entry_in.dx     = spa_pkg::DELTA_W'(other_x) - spa_pkg::DELTA_W'(self_x);
        entry_in.dy     = spa_pkg::DELTA_W'(other_y) - spa_pkg::DELTA_W'(self_y);
        entry_in.dz     = spa_pkg::DELTA_W'(other_z) - spa_pkg::DELTA_W'(self_z);
        entry_in.rest   = spa_pkg::REST_W'(self_radius) + spa_pkg::REST_W'(other_radius);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ----- sv/spa_div.sv -----
// ----------------------------------------------------------------------------
// spa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module spa_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [spa_pkg::NUM_W-1:0]    num,
    input  logic [spa_pkg::DEN_W-1:0]    den,
    output logic [spa_pkg::QUO_W-1:0]    quo,
    output logic                         idle
);

    localparam int CNT_W = $clog2(spa_pkg::QUO_W + 1);
    localparam int HI_W  = spa_pkg::NUM_W - spa_pkg::QUO_W;

    logic [spa_pkg::DEN_W-1:0] rem_reg;
    logic [spa_pkg::DEN_W-1:0] den_reg;
    logic [spa_pkg::QUO_W-1:0] sh_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic [spa_pkg::DEN_W:0]   trial;
    logic [spa_pkg::DEN_W:0]   diff;
    logic                      ge;

    assign trial = {rem_reg, sh_reg[spa_pkg::QUO_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign quo   = sh_reg;
    assign idle  = !busy_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(spa_pkg::DEN_W - HI_W){1'b0}}, num[spa_pkg::NUM_W-1:spa_pkg::QUO_W]};
            sh_reg  <= num[spa_pkg::QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[spa_pkg::DEN_W-1:0] : trial[spa_pkg::DEN_W-1:0];
            sh_reg  <= {sh_reg[spa_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(spa_pkg::QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/spa_back.sv -----
// ----------------------------------------------------------------------------
// spa_back
// per-spring sequencer: distance, extension, force terms, saturating sums
// ----------------------------------------------------------------------------
`include "spring_pair_force_accumulator_unit_assert.svh"

module spa_back
#(
    parameter int MAX_SPRINGS = spa_pkg::MAX_SPRINGS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  spa_pkg::pair_t                    q_head,
    output logic                              q_pop,
    input  logic [spa_pkg::K_W-1:0]           stiffness,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [spa_pkg::SUM_W-1:0]  force_x,
    output logic signed [spa_pkg::SUM_W-1:0]  force_y,
    output logic signed [spa_pkg::SUM_W-1:0]  force_z,
    output logic [spa_pkg::CNT_W-1:0]         springs_applied,
    output logic                              saturated
);

    localparam int FW    = spa_pkg::QUO_W + 1;
    localparam int ACC_W = ((FW > spa_pkg::SUM_W) ? FW : spa_pkg::SUM_W) + 1;
    localparam int SC_W  = $clog2(spa_pkg::D_W + 1);
    localparam int PR_W  = 32 + spa_pkg::UE_W;
    localparam int CAP_V = (MAX_SPRINGS < 127) ? MAX_SPRINGS : 127;
    localparam logic [spa_pkg::CNT_W-1:0] CAP = spa_pkg::CNT_W'(CAP_V);
    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W - spa_pkg::SUM_W + 1){1'b0}}, {(spa_pkg::SUM_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;

    typedef struct packed {
        logic [spa_pkg::SUM_W-1:0] sum;
        logic                      clamp;
    } sat_t;

    function automatic logic [spa_pkg::DELTA_W-1:0] mag_of(
        input logic signed [spa_pkg::DELTA_W-1:0] v);
        return v[spa_pkg::DELTA_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic sat_t sat_add(input logic signed [spa_pkg::SUM_W-1:0] s,
                                     input logic neg,
                                     input logic [spa_pkg::QUO_W-1:0] mag);
        logic signed [ACC_W-1:0] a;
        logic signed [ACC_W-1:0] f;
        logic signed [ACC_W-1:0] t;
        sat_t                    r;
        a = ACC_W'(s);
        f = ACC_W'($signed({1'b0, mag}));
        if (neg)
        begin
            f = -f;
        end
        t = a + f;
        r.clamp = 1'b0;
        r.sum   = t[spa_pkg::SUM_W-1:0];
        if (t > SMAX)
        begin
            r.sum   = SMAX[spa_pkg::SUM_W-1:0];
            r.clamp = 1'b1;
        end
        else if (t < SMIN)
        begin
            r.sum   = SMIN[spa_pkg::SUM_W-1:0];
            r.clamp = 1'b1;
        end
        return r;
    endfunction

    spa_pkg::seq_state_t state_reg;
    spa_pkg::seq_state_t state_next;

    logic signed [spa_pkg::DELTA_W-1:0] dx_reg;
    logic signed [spa_pkg::DELTA_W-1:0] dy_reg;
    logic signed [spa_pkg::DELTA_W-1:0] dz_reg;
    logic [spa_pkg::REST_W-1:0]         rest_reg;
    logic                               last_reg;
    logic                               skip_reg;
    logic [spa_pkg::SQR_W-1:0]          sqx_reg;
    logic [spa_pkg::SQR_W-1:0]          sqy_reg;
    logic [spa_pkg::SQR_W-1:0]          sqz_reg;
    logic [spa_pkg::SQ_W-1:0]           sq_sh_reg;
    logic [spa_pkg::RT_W-1:0]           rem_reg;
    logic [spa_pkg::D_W-1:0]            root_reg;
    logic [SC_W-1:0]                    sqrt_cnt_reg;
    logic [spa_pkg::UE_W-1:0]           ue_reg;
    logic                               ext_neg_reg;
    logic [spa_pkg::KUD_W-1:0]          kud_x_reg;
    logic [spa_pkg::KUD_W-1:0]          kud_y_reg;
    logic [spa_pkg::KUD_W-1:0]          kud_z_reg;
    logic [PR_W-1:0]                    plo_x_reg;
    logic [PR_W-1:0]                    plo_y_reg;
    logic [PR_W-1:0]                    plo_z_reg;
    logic [PR_W-1:0]                    phi_x_reg;
    logic [PR_W-1:0]                    phi_y_reg;
    logic [PR_W-1:0]                    phi_z_reg;
    logic [spa_pkg::NUM_W-1:0]          num_x_reg;
    logic [spa_pkg::NUM_W-1:0]          num_y_reg;
    logic [spa_pkg::NUM_W-1:0]          num_z_reg;
    logic signed [spa_pkg::SUM_W-1:0]   sum_x_reg;
    logic signed [spa_pkg::SUM_W-1:0]   sum_y_reg;
    logic signed [spa_pkg::SUM_W-1:0]   sum_z_reg;
    logic [spa_pkg::CNT_W-1:0]          pair_count_reg;
    logic                               clamp_seen_reg;
    logic                               result_valid_reg;
    logic signed [spa_pkg::SUM_W-1:0]   force_x_reg;
    logic signed [spa_pkg::SUM_W-1:0]   force_y_reg;
    logic signed [spa_pkg::SUM_W-1:0]   force_z_reg;
    logic [spa_pkg::CNT_W-1:0]          springs_reg;
    logic                               saturated_reg;

    logic [spa_pkg::DELTA_W-1:0] ax;
    logic [spa_pkg::DELTA_W-1:0] ay;
    logic [spa_pkg::DELTA_W-1:0] az;
    logic [spa_pkg::SQ_W-1:0]    sq_sum;
    logic [spa_pkg::RT_W-1:0]    rem_sh;
    logic [spa_pkg::RT_W-1:0]    rt_trial;
    logic                        rt_ge;
    logic signed [spa_pkg::UE_W-1:0] ext;
    logic [spa_pkg::DELTA_W+spa_pkg::K_W-1:0] kp_x;
    logic [spa_pkg::DELTA_W+spa_pkg::K_W-1:0] kp_y;
    logic [spa_pkg::DELTA_W+spa_pkg::K_W-1:0] kp_z;
    logic [spa_pkg::DEN_W-1:0]   den;
    logic [spa_pkg::QUO_W-1:0]   quo_x;
    logic [spa_pkg::QUO_W-1:0]   quo_y;
    logic [spa_pkg::QUO_W-1:0]   quo_z;
    logic                        idle_x;
    logic                        idle_y;
    logic                        idle_z;
    logic                        div_idle;
    logic                        div_start;
    logic                        blocked;
    logic                        acc_fire;
    sat_t                        nx;
    sat_t                        ny;
    sat_t                        nz;
    logic signed [spa_pkg::SUM_W-1:0] new_x;
    logic signed [spa_pkg::SUM_W-1:0] new_y;
    logic signed [spa_pkg::SUM_W-1:0] new_z;
    logic [spa_pkg::CNT_W-1:0]   new_count;
    logic                        new_clamp;

    assign ax       = mag_of(dx_reg);
    assign ay       = mag_of(dy_reg);
    assign az       = mag_of(dz_reg);
    assign sq_sum   = spa_pkg::SQ_W'(sqx_reg) + spa_pkg::SQ_W'(sqy_reg)
                    + spa_pkg::SQ_W'(sqz_reg);
    assign rem_sh   = {rem_reg[spa_pkg::RT_W-3:0], sq_sh_reg[spa_pkg::SQ_W-1 -: 2]};
    assign rt_trial = {{(spa_pkg::RT_W - spa_pkg::D_W - 2){1'b0}}, root_reg, 2'b01};
    assign rt_ge    = (rem_sh >= rt_trial);
    assign ext      = $signed({1'b0, root_reg}) - $signed(spa_pkg::UE_W'(rest_reg));
    assign kp_x     = stiffness * ax;
    assign kp_y     = stiffness * ay;
    assign kp_z     = stiffness * az;
    assign den      = {root_reg, {spa_pkg::FRACTION_BITS{1'b0}}};
    assign div_idle = idle_x && idle_y && idle_z;
    assign blocked  = last_reg && result_valid_reg && result_stall;

    spa_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .num(num_x_reg),
                     .den(den), .quo(quo_x), .idle(idle_x));
    spa_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .num(num_y_reg),
                     .den(den), .quo(quo_y), .idle(idle_y));
    spa_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .num(num_z_reg),
                     .den(den), .quo(quo_z), .idle(idle_z));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_head.active ? spa_pkg::ST_SQUARE : spa_pkg::ST_ACC;
                end
            end
            spa_pkg::ST_SQUARE: state_next = spa_pkg::ST_SUMSQ;
            spa_pkg::ST_SUMSQ:
            begin
                state_next = (sq_sum == '0) ? spa_pkg::ST_ACC : spa_pkg::ST_SQRT;
            end
            spa_pkg::ST_SQRT:
            begin
                if (sqrt_cnt_reg == SC_W'(1))
                begin
                    state_next = spa_pkg::ST_EXT;
                end
            end
            spa_pkg::ST_EXT:   state_next = spa_pkg::ST_KMUL;
            spa_pkg::ST_KMUL:  state_next = spa_pkg::ST_PMUL;
            spa_pkg::ST_PMUL:  state_next = spa_pkg::ST_PSUM;
            spa_pkg::ST_PSUM:  state_next = spa_pkg::ST_DIVGO;
            spa_pkg::ST_DIVGO: state_next = spa_pkg::ST_DIV;
            spa_pkg::ST_DIV:
            begin
                if (div_idle)
                begin
                    state_next = spa_pkg::ST_ACC;
                end
            end
            spa_pkg::ST_ACC:
            begin
                if (!blocked)
                begin
                    state_next = spa_pkg::ST_IDLE;
                end
            end
            default: state_next = spa_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop     = (state_reg == spa_pkg::ST_IDLE) && q_valid;
        div_start = (state_reg == spa_pkg::ST_DIVGO);
        acc_fire  = (state_reg == spa_pkg::ST_ACC) && !blocked;
    end

    // force terms and saturating sums
    always_comb
    begin
        nx = sat_add(sum_x_reg, ext_neg_reg ^ dx_reg[spa_pkg::DELTA_W-1], quo_x);
        ny = sat_add(sum_y_reg, ext_neg_reg ^ dy_reg[spa_pkg::DELTA_W-1], quo_y);
        nz = sat_add(sum_z_reg, ext_neg_reg ^ dz_reg[spa_pkg::DELTA_W-1], quo_z);
        if (skip_reg)
        begin
            new_x     = sum_x_reg;
            new_y     = sum_y_reg;
            new_z     = sum_z_reg;
            new_clamp = clamp_seen_reg;
            new_count = pair_count_reg;
        end
        else
        begin
            new_x     = nx.sum;
            new_y     = ny.sum;
            new_z     = nz.sum;
            new_clamp = clamp_seen_reg || nx.clamp || ny.clamp || nz.clamp;
            new_count = (pair_count_reg < CAP) ? pair_count_reg + 1'b1 : pair_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                dx_reg   <= q_head.dx;
                dy_reg   <= q_head.dy;
                dz_reg   <= q_head.dz;
                rest_reg <= q_head.rest;
                last_reg <= q_head.last;
                skip_reg <= !q_head.active;
            end
            spa_pkg::ST_SQUARE:
            begin
                sqx_reg <= ax * ax;
                sqy_reg <= ay * ay;
                sqz_reg <= az * az;
            end
            spa_pkg::ST_SUMSQ:
            begin
                sq_sh_reg    <= sq_sum;
                rem_reg      <= '0;
                root_reg     <= '0;
                sqrt_cnt_reg <= SC_W'(spa_pkg::D_W);
                skip_reg     <= (sq_sum == '0);
            end
            spa_pkg::ST_SQRT:
            begin
                sq_sh_reg    <= {sq_sh_reg[spa_pkg::SQ_W-3:0], 2'b00};
                rem_reg      <= rt_ge ? (rem_sh - rt_trial) : rem_sh;
                root_reg     <= {root_reg[spa_pkg::D_W-2:0], rt_ge};
                sqrt_cnt_reg <= sqrt_cnt_reg - 1'b1;
            end
            spa_pkg::ST_EXT:
            begin
                ext_neg_reg <= ext[spa_pkg::UE_W-1];
                ue_reg      <= ext[spa_pkg::UE_W-1] ? spa_pkg::UE_W'(-ext) : spa_pkg::UE_W'(ext);
            end
            spa_pkg::ST_KMUL:
            begin
                kud_x_reg <= kp_x[spa_pkg::KUD_W-1:0];
                kud_y_reg <= kp_y[spa_pkg::KUD_W-1:0];
                kud_z_reg <= kp_z[spa_pkg::KUD_W-1:0];
            end
            spa_pkg::ST_PMUL:
            begin
                plo_x_reg <= kud_x_reg[31:0] * ue_reg;
                plo_y_reg <= kud_y_reg[31:0] * ue_reg;
                plo_z_reg <= kud_z_reg[31:0] * ue_reg;
                phi_x_reg <= kud_x_reg[63:32] * ue_reg;
                phi_y_reg <= kud_y_reg[63:32] * ue_reg;
                phi_z_reg <= kud_z_reg[63:32] * ue_reg;
            end
            spa_pkg::ST_PSUM:
            begin
                num_x_reg <= spa_pkg::NUM_W'(plo_x_reg) + spa_pkg::NUM_W'({phi_x_reg, 32'b0});
                num_y_reg <= spa_pkg::NUM_W'(plo_y_reg) + spa_pkg::NUM_W'({phi_y_reg, 32'b0});
                num_z_reg <= spa_pkg::NUM_W'(plo_z_reg) + spa_pkg::NUM_W'({phi_z_reg, 32'b0});
            end
            spa_pkg::ST_DIVGO,
            spa_pkg::ST_DIV,
            spa_pkg::ST_ACC:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // running sums and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_z_reg        <= '0;
            pair_count_reg   <= '0;
            clamp_seen_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc_fire && last_reg)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (acc_fire)
            begin
                if (last_reg)
                begin
                    sum_x_reg      <= '0;
                    sum_y_reg      <= '0;
                    sum_z_reg      <= '0;
                    pair_count_reg <= '0;
                    clamp_seen_reg <= 1'b0;
                end
                else
                begin
                    sum_x_reg      <= new_x;
                    sum_y_reg      <= new_y;
                    sum_z_reg      <= new_z;
                    pair_count_reg <= new_count;
                    clamp_seen_reg <= new_clamp;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_fire && last_reg)
        begin
            force_x_reg   <= new_x;
            force_y_reg   <= new_y;
            force_z_reg   <= new_z;
            springs_reg   <= new_count;
            saturated_reg <= new_clamp;
        end
    end

    assign result_valid    = result_valid_reg;
    assign force_x         = force_x_reg;
    assign force_y         = force_y_reg;
    assign force_z         = force_z_reg;
    assign springs_applied = springs_reg;
    assign saturated       = saturated_reg;

    `SPA_ASSERT_NXT(a_div_to_acc, clk, rst_n, (state_reg == spa_pkg::ST_DIV) && div_idle, (state_reg == spa_pkg::ST_ACC))
    `SPA_ASSERT_IMP(a_sqrt_count, clk, rst_n, (state_reg == spa_pkg::ST_SQRT), (sqrt_cnt_reg != '0))
    `SPA_ASSERT_NXT(a_emit, clk, rst_n, acc_fire && last_reg, result_valid_reg && (pair_count_reg == '0))
    `SPA_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, (pair_count_reg <= CAP))

endmodule
